@@ design/srep_pkg.sv @@
// Shared types and constants of the substring replace engine.
`default_nettype none

package srep_pkg;

   localparam int BYTE_W      = 8;
   localparam int MAX_RESULTS = 8;
   localparam int SEQ_W       = MAX_RESULTS * BYTE_W;
   localparam int LEN_W       = 4;
   localparam int COUNT_W     = 16;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 64;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
   localparam logic [LEN_W-1:0]   REP_LEN_MAX = LEN_W'(MAX_RESULTS);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PATTERN_BYTES      = 8'd0,
      REG_PATTERN_LENGTH     = 8'd1,
      REG_REPLACEMENT_BYTES  = 8'd2,
      REG_REPLACEMENT_LENGTH = 8'd3
   } reg_index_type;

   // one item's worth of results, handed to the serializer
   typedef struct packed {
      logic [SEQ_W-1:0]   seq;    // first result in bits 7..0
      logic [LEN_W-1:0]   n;      // entries to send, 1..8
      logic               bare;   // single end marker without a byte
      logic               last;   // final entry closes the text
      logic [COUNT_W-1:0] count;  // replacement count for the closing entry
   } burst_type;

endpackage

`default_nettype wire

@@ design/srep_if.sv @@
// Channel interfaces of the substring replace engine.
`default_nettype none

interface srep_req_if;
   logic                       valid;
   logic                       ready;
   logic [srep_pkg::BYTE_W-1:0] in_byte;
   logic                       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface srep_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [srep_pkg::BYTE_W-1:0]  out_byte;
   logic                         out_valid;
   logic                         out_last;
   logic [srep_pkg::COUNT_W-1:0] replace_count;

   modport source (output valid, output out_byte, output out_valid, output out_last,
                   output replace_count, input ready);
   modport sink   (input valid, input out_byte, input out_valid, input out_last,
                   input replace_count, output ready);
endinterface

interface srep_csr_if;
   logic                             valid;
   logic                             ready;
   logic [srep_pkg::CSR_INDEX_W-1:0] reg_index;
   logic [srep_pkg::CSR_DATA_W-1:0]  reg_data;

   modport source (output valid, output reg_index, output reg_data, input ready);
   modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

`default_nettype wire

@@ design/srep_cell.sv @@
// One window cell: holds a text byte, compares it to its pattern byte, shifts left.
`default_nettype none

module srep_cell (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic                        sel_new,
   input  wire logic                        shift,
   input  wire logic [srep_pkg::BYTE_W-1:0] new_byte,
   input  wire logic [srep_pkg::BYTE_W-1:0] right_byte,
   input  wire logic [srep_pkg::BYTE_W-1:0] pat_byte,
   output logic      [srep_pkg::BYTE_W-1:0] cur_byte,
   output logic                             hit
);
   import srep_pkg::*;

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;

   // window content with the incoming byte placed
   assign cur_byte = sel_new ? new_byte : byte_ff;
   assign hit      = (cur_byte == pat_byte);
   assign byte_in  = shift ? right_byte : cur_byte;

   always_ff @(posedge clock) begin
      if (en) begin
         byte_ff <= byte_in;
      end
   end

endmodule

`default_nettype wire

@@ design/srep_burst.sv @@
// Result serializer: sends one item's results a word per ready cycle via an output register.
`default_nettype none

module srep_burst (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load_valid,
   input  wire srep_pkg::burst_type load,
   output logic                     can_load,
   srep_rsp_if.source               rsp_bus
);
   import srep_pkg::*;

   logic [SEQ_W-1:0]   seq_ff,   seq_in;
   logic [LEN_W-1:0]   rem_ff,   rem_in;
   logic               bare_ff,  bare_in;
   logic               last_ff,  last_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               rsp_valid_ff,   rsp_valid_in;
   logic [BYTE_W-1:0]  out_byte_ff,    out_byte_in;
   logic               out_valid_ff,   out_valid_in;
   logic               out_last_ff,    out_last_in;
   logic [COUNT_W-1:0] rsp_count_ff,   rsp_count_in;

   logic emit;
   logic final_entry;

   assign emit        = (rem_ff != '0) && (!rsp_valid_ff || rsp_bus.ready);
   assign final_entry = (rem_ff == LEN_W'(1));
   assign can_load    = (rem_ff == '0) || (emit && final_entry);

   always_comb begin
      seq_in   = seq_ff;
      rem_in   = rem_ff;
      bare_in  = bare_ff;
      last_in  = last_ff;
      count_in = count_ff;
      if (load_valid) begin
         seq_in   = load.seq;
         rem_in   = load.n;
         bare_in  = load.bare;
         last_in  = load.last;
         count_in = load.count;
      end else if (emit) begin
         seq_in = seq_ff >> BYTE_W;
         rem_in = rem_ff - LEN_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_byte_in  = out_byte_ff;
      out_valid_in = out_valid_ff;
      out_last_in  = out_last_ff;
      rsp_count_in = rsp_count_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         out_byte_in  = bare_ff ? '0 : seq_ff[BYTE_W-1:0];
         out_valid_in = !bare_ff;
         out_last_in  = last_ff && final_entry;
         rsp_count_in = (last_ff && final_entry) ? count_ff : '0;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff       <= seq_in;
      bare_ff      <= bare_in;
      last_ff      <= last_in;
      count_ff     <= count_in;
      out_byte_ff  <= out_byte_in;
      out_valid_ff <= out_valid_in;
      out_last_ff  <= out_last_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.out_byte      = out_byte_ff;
   assign rsp_bus.out_valid     = out_valid_ff;
   assign rsp_bus.out_last      = out_last_ff;
   assign rsp_bus.replace_count = rsp_count_ff;

`ifndef SYNTH
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= REP_LEN_MAX)
      else $error("serializer holds more entries than one item can make");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_valid |-> can_load)
      else $error("results loaded over a pending burst");

   a_bare_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !out_valid_ff) |-> out_last_ff)
      else $error("bare end marker without last flag");
`endif

endmodule

`default_nettype wire

@@ design/substring_replace_engine.sv @@
// Top level of the streaming substring replace engine.
// Channels: req_bus takes one text byte per word, in_last marks the final byte
// of a text. rsp_bus gives result words: out_byte with out_valid, out_last on
// the final word of a text, replace_count (saturating at 65535) with out_last.
// csr_bus writes the pattern, its length, the replacement and its length; a
// pattern length write clears the window. csr_bus is always ready.
// The window is a row of cells, one byte each; the incoming byte is compared
// against the pattern in all cells in the cycle it is accepted.
// The first result of a byte goes through the serializer's item register, then its output register.
// Throughput: one byte per cycle while each byte yields at most one result.
// A match or an end of text can yield up to 8 results; the serializer sends
// one per cycle and req_bus.ready stays low until its last one goes out.
// A stalled rsp_bus holds the output register; one further burst waits
// behind it before req_bus.ready drops.
// Reset empties the window, the count and the serializer, and sets the
// pattern length to 1 and the replacement length to 0.
`default_nettype none

module substring_replace_engine #(
   parameter int MAX_PATTERN = 8
) (
   input  wire logic  clock,
   input  wire logic  reset,
   srep_req_if.sink   req_bus,
   srep_rsp_if.source rsp_bus,
   srep_csr_if.sink   csr_bus
);
   import srep_pkg::*;

   localparam int WIN    = (MAX_PATTERN < MAX_RESULTS) ? MAX_PATTERN : MAX_RESULTS;
   localparam int FILL_W = $clog2(WIN + 1);

   logic [SEQ_W-1:0]   pattern_bytes_ff,      pattern_bytes_in;
   logic [LEN_W-1:0]   pattern_length_ff,     pattern_length_in;
   logic [SEQ_W-1:0]   replacement_bytes_ff,  replacement_bytes_in;
   logic [LEN_W-1:0]   replacement_length_ff, replacement_length_in;
   logic [FILL_W-1:0]  fill_ff,               fill_in;
   logic [COUNT_W-1:0] match_total_ff,        match_total_in;

   logic               accept;
   logic               csr_write;
   logic               can_load;
   logic [LEN_W-1:0]   eff_len;
   logic [LEN_W-1:0]   rep_len;
   logic [LEN_W-1:0]   fill_w;
   logic [LEN_W-1:0]   fill_eff;
   logic [LEN_W-1:0]   new_fill;
   logic               full;
   logic               matched;
   logic               shift;
   logic [LEN_W-1:0]   res_n;
   logic [COUNT_W-1:0] total_step;
   logic [SEQ_W-1:0]   win_seq;
   logic               load_valid;
   burst_type          load;

   logic [BYTE_W-1:0]  cur_bytes [WIN];
   logic [WIN-1:0]     hits;
   logic [WIN-1:0]     len_mask;

   assign accept    = req_bus.valid && req_bus.ready;
   assign csr_write = csr_bus.valid && csr_bus.ready;
   assign csr_bus.ready = 1'b1;

   // configuration registers
   always_comb begin
      pattern_bytes_in      = pattern_bytes_ff;
      pattern_length_in     = pattern_length_ff;
      replacement_bytes_in  = replacement_bytes_ff;
      replacement_length_in = replacement_length_ff;
      if (csr_write) begin
         case (csr_bus.reg_index)
            REG_PATTERN_BYTES:      pattern_bytes_in      = csr_bus.reg_data;
            REG_PATTERN_LENGTH:     pattern_length_in     = csr_bus.reg_data[LEN_W-1:0];
            REG_REPLACEMENT_BYTES:  replacement_bytes_in  = csr_bus.reg_data;
            REG_REPLACEMENT_LENGTH: replacement_length_in = csr_bus.reg_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (pattern_length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (pattern_length_ff > LEN_W'(WIN)) begin
         eff_len = LEN_W'(WIN);
      end else begin
         eff_len = pattern_length_ff;
      end
      rep_len = (replacement_length_ff > REP_LEN_MAX) ? REP_LEN_MAX : replacement_length_ff;
   end

   assign fill_w   = LEN_W'(fill_ff);
   assign fill_eff = (fill_w >= eff_len) ? (eff_len - LEN_W'(1)) : fill_w;
   assign new_fill = fill_eff + LEN_W'(1);
   assign full     = (new_fill == eff_len);
   assign matched  = full && (&(hits | ~len_mask));
   assign shift    = full && !matched;

   // window cells
   for (genvar i = 0; i < WIN; i++) begin : g_cell
      logic [BYTE_W-1:0] right_byte;
      if (i == WIN - 1) begin : g_end
         assign right_byte = '0;
      end else begin : g_mid
         assign right_byte = cur_bytes[i+1];
      end
      assign len_mask[i] = (LEN_W'(i) < eff_len);

      srep_cell u_cell (
         .clock      (clock),
         .en         (accept),
         .sel_new    (fill_eff == LEN_W'(i)),
         .shift      (shift),
         .new_byte   (req_bus.in_byte),
         .right_byte (right_byte),
         .pat_byte   (pattern_bytes_ff[i*BYTE_W +: BYTE_W]),
         .cur_byte   (cur_bytes[i]),
         .hit        (hits[i])
      );
   end

   always_comb begin
      win_seq = '0;
      for (int i = 0; i < WIN; i++) begin
         win_seq[i*BYTE_W +: BYTE_W] = cur_bytes[i];
      end
   end

   // on a miss the window bytes go out oldest first: one if full, all on the last byte
   always_comb begin
      if (matched) begin
         res_n = rep_len;
      end else if (req_bus.in_last) begin
         res_n = new_fill;
      end else if (full) begin
         res_n = LEN_W'(1);
      end else begin
         res_n = '0;
      end
   end

   assign total_step = (matched && (match_total_ff != COUNT_MAX)) ?
                       (match_total_ff + COUNT_W'(1)) : match_total_ff;

   always_comb begin
      fill_in        = fill_ff;
      match_total_in = match_total_ff;
      if (csr_write && (csr_bus.reg_index == REG_PATTERN_LENGTH)) begin
         fill_in = '0;
      end else if (accept) begin
         if (req_bus.in_last || matched) begin
            fill_in = '0;
         end else if (shift) begin
            fill_in = FILL_W'(fill_eff);
         end else begin
            fill_in = FILL_W'(new_fill);
         end
      end
      if (accept) begin
         match_total_in = req_bus.in_last ? '0 : total_step;
      end
   end

   assign load_valid = accept && ((res_n != '0) || req_bus.in_last);
   assign load.seq   = matched ? replacement_bytes_ff : win_seq;
   assign load.n     = (res_n == '0) ? LEN_W'(1) : res_n;
   assign load.bare  = (res_n == '0);
   assign load.last  = req_bus.in_last;
   assign load.count = total_step;

   assign req_bus.ready = can_load;

   srep_burst u_burst (
      .clock      (clock),
      .reset      (reset),
      .load_valid (load_valid),
      .load       (load),
      .can_load   (can_load),
      .rsp_bus    (rsp_bus)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff      <= '0;
         pattern_length_ff     <= LEN_W'(1);
         replacement_bytes_ff  <= '0;
         replacement_length_ff <= '0;
         fill_ff               <= '0;
         match_total_ff        <= '0;
      end else begin
         pattern_bytes_ff      <= pattern_bytes_in;
         pattern_length_ff     <= pattern_length_in;
         replacement_bytes_ff  <= replacement_bytes_in;
         replacement_length_ff <= replacement_length_in;
         fill_ff               <= fill_in;
         match_total_ff        <= match_total_in;
      end
   end

`ifndef SYNTH
   a_fill_below_len: assert property (@(posedge clock) disable iff (reset)
      LEN_W'(fill_ff) < eff_len)
      else $error("window holds a full pattern between words");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.in_last) |=> (fill_ff == '0) && (match_total_ff == '0))
      else $error("state not cleared after end of text");

   a_match_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && matched) |=> (fill_ff == '0))
      else $error("window not emptied after a match");
`endif

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Testbench of the substring replace engine: directed and random texts checked word by word.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import srep_pkg::*;

   // smaller of 8 and the engine's MAX_PATTERN (default instance)
   localparam int WINDOW_CAP = 8;

   typedef struct packed {
      logic [BYTE_W-1:0]  text_byte;
      logic               has_byte;
      logic               last;
      logic [COUNT_W-1:0] count;
   } out_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   srep_req_if req_bus ();
   srep_rsp_if rsp_bus ();
   srep_csr_if csr_bus ();

   substring_replace_engine dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #6 clock = ~clock;

   // replace predictor: configuration and window state
   logic [63:0]  pat_bytes_cfg;
   logic [3:0]   pat_len_cfg;
   logic [63:0]  rep_bytes_cfg;
   logic [3:0]   rep_len_cfg;
   logic [7:0]   win [8];
   int unsigned  win_fill;
   int unsigned  match_total;

   out_word_type expected_words [$];
   int           error_count = 0;
   int           words_checked = 0;
   int           burst_left = 0;

   task automatic report_mismatch(input string what);
      $display("%0t ns  word %0d: %s", $time, words_checked, what);
      error_count++;
   endtask

   function automatic void clear_window();
      for (int k = 0; k < 8; k++) win[k] = 8'h00;
      win_fill = 0;
   endfunction

   function automatic int unsigned active_pat_len();
      int unsigned l;
      l = pat_len_cfg;
      if (l == 0) l = 1;
      if (l > WINDOW_CAP) l = WINDOW_CAP;
      return l;
   endfunction

   function automatic void note_reg_write(input reg_index_type idx, input logic [63:0] data);
      case (idx)
         REG_PATTERN_BYTES: pat_bytes_cfg = data;
         REG_PATTERN_LENGTH: begin
            pat_len_cfg = data[3:0];
            clear_window();
         end
         REG_REPLACEMENT_BYTES: rep_bytes_cfg = data;
         REG_REPLACEMENT_LENGTH: rep_len_cfg = data[3:0];
         default: ;
      endcase
   endfunction

   // works out the words one accepted text byte causes
   function automatic void predict_replace(input logic [7:0] text_byte, input logic last);
      out_word_type words [9];
      int           n;
      int unsigned  len;
      int unsigned  rlen;
      logic         hit;
      n = 0;
      len = active_pat_len();
      rlen = (rep_len_cfg > 8) ? 8 : rep_len_cfg;
      if (win_fill >= len) win_fill = len - 1;
      win[win_fill & 7] = text_byte;
      win_fill++;
      if (win_fill == len) begin
         hit = 1'b1;
         for (int k = 0; k < len; k++)
            if (win[k] != pat_bytes_cfg[8*k +: 8]) hit = 1'b0;
         if (hit) begin
            for (int k = 0; k < rlen; k++) begin
               words[n] = {rep_bytes_cfg[8*k +: 8], 1'b1, 1'b0, 16'd0};
               n++;
            end
            win_fill = 0;
            if (match_total < 32'hFFFF) match_total++;
         end else begin
            words[n] = {win[0], 1'b1, 1'b0, 16'd0};
            n++;
            for (int k = 1; k < 8; k++) win[k-1] = win[k];
            win[7] = 8'h00;
            win_fill--;
         end
      end
      if (last) begin
         for (int k = 0; k < win_fill; k++) begin
            words[n] = {win[k], 1'b1, 1'b0, 16'd0};
            n++;
         end
         // nothing left to send: bare end marker
         if (n == 0) begin
            words[n] = {8'h00, 1'b0, 1'b0, 16'd0};
            n++;
         end
         words[n-1].last = 1'b1;
         words[n-1].count = match_total[15:0];
         clear_window();
         match_total = 0;
      end
      for (int k = 0; k < n; k++) expected_words = {expected_words, words[k]};
   endfunction

   task automatic send_byte(input logic [7:0] text_byte, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= text_byte;
      req_bus.in_last <= last;
      do @(posedge clock); while (!req_bus.ready);
      predict_replace(text_byte, last);
   endtask

   // more: another write follows at once, keep csr valid up
   task automatic write_reg(input reg_index_type idx, input logic [63:0] data,
                            input bit more = 1'b0);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.reg_data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      if (!more) csr_bus.valid <= 1'b0;
      note_reg_write(idx, data);
   endtask

   // stop sending, wait for all words, then let the pipeline drain
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // result checker with its own stall pattern
   initial begin
      out_word_type want;
      int           stall_mode;
      int           mode_left;
      stall_mode = 0;
      mode_left = 0;
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word byte %02h valid %0b last %0b",
                  rsp_bus.out_byte, rsp_bus.out_valid, rsp_bus.out_last));
            end else begin
               want = expected_words.pop_front();
               if (rsp_bus.out_byte !== want.text_byte)
                  report_mismatch($sformatf("out_byte %02h, expected %02h",
                     rsp_bus.out_byte, want.text_byte));
               if (rsp_bus.out_valid !== want.has_byte)
                  report_mismatch($sformatf("out_valid %0b, expected %0b",
                     rsp_bus.out_valid, want.has_byte));
               if (rsp_bus.out_last !== want.last)
                  report_mismatch($sformatf("out_last %0b, expected %0b",
                     rsp_bus.out_last, want.last));
               if (rsp_bus.replace_count !== want.count)
                  report_mismatch($sformatf("replace_count %0d, expected %0d",
                     rsp_bus.replace_count, want.count));
            end
            words_checked++;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(8, 80);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 1) == 0);
            default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // reset settings: pattern 00, length 1, empty replacement
   task automatic test_reset_defaults();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   task automatic test_match_and_flush();
      settle();
      write_reg(REG_PATTERN_BYTES, 64'hDEAD_BEEF_0063_6261, 1'b1);
      write_reg(REG_PATTERN_LENGTH, 64'h0000_0000_0000_0003, 1'b1);
      write_reg(REG_REPLACEMENT_BYTES, 64'h1234_5678_9ABC_5958, 1'b1);
      write_reg(REG_REPLACEMENT_LENGTH, 64'h0000_0000_0000_0002);
      send_byte(8'h61, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h63, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b1);
   endtask

   task automatic test_length_limits();
      settle();
      // length 0 acts as 1, replacement length 15 as 8
      write_reg(REG_PATTERN_BYTES, 64'h0000_0000_0000_0061, 1'b1);
      write_reg(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0, 1'b1);
      write_reg(REG_REPLACEMENT_BYTES, 64'h0807_0605_0403_0201, 1'b1);
      write_reg(REG_REPLACEMENT_LENGTH, 64'h0000_0000_0000_000F);
      send_byte(8'h61, 1'b0);
      send_byte(8'h7A, 1'b1);
      settle();
      // length 15 saturates to the window, zero replacement deletes
      write_reg(REG_PATTERN_BYTES, 64'h6867_6665_6463_6261, 1'b1);
      write_reg(REG_PATTERN_LENGTH, 64'h0000_0000_0000_000F, 1'b1);
      write_reg(REG_REPLACEMENT_LENGTH, 64'h0000_0000_0000_0000);
      for (int k = 0; k < 8; k++) send_byte(8'h61 + 8'(k), k == 7);
   endtask

   task automatic test_midtext_writes();
      settle();
      write_reg(REG_PATTERN_BYTES, 64'h0000_0000_0063_6261, 1'b1);
      write_reg(REG_PATTERN_LENGTH, 64'h0000_0000_0000_0003, 1'b1);
      write_reg(REG_REPLACEMENT_BYTES, 64'h0000_0000_0000_5958, 1'b1);
      write_reg(REG_REPLACEMENT_LENGTH, 64'h0000_0000_0000_0002);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      settle();
      // length write drops the held "ab"
      write_reg(REG_PATTERN_LENGTH, 64'h0000_0000_0000_0003);
      send_byte(8'h63, 1'b1);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      settle();
      // new pattern bytes apply to the held window at once
      write_reg(REG_PATTERN_BYTES, 64'h0000_0000_0064_6261);
      send_byte(8'h64, 1'b1);
   endtask

   // every byte is a deleted match, the bare end marker carries the count
   task automatic test_match_count();
      settle();
      write_reg(REG_PATTERN_BYTES, 64'h0000_0000_0000_00A5, 1'b1);
      write_reg(REG_PATTERN_LENGTH, 64'h0000_0000_0000_0001, 1'b1);
      write_reg(REG_REPLACEMENT_LENGTH, 64'h0000_0000_0000_0000);
      for (int k = 0; k < 6; k++) send_byte(8'hA5, k == 5);
   endtask

   task automatic test_random_texts();
      logic [7:0]  sym [3];
      logic [7:0]  seg [$];
      logic [63:0] pat;
      logic [3:0]  plen;
      logic [3:0]  rlen;
      int          budget;
      int          cut;
      int          pick;
      int unsigned len;
      for (int phase = 0; phase < 10; phase++) begin
         settle();
         for (int k = 0; k < 3; k++) sym[k] = 8'($urandom);
         case (phase)
            0: begin plen = 4'd8;  rlen = 4'd8;  end
            1: begin plen = 4'd1;  rlen = 4'd0;  end
            2: begin plen = 4'd15; rlen = 4'd15; end
            default: begin
               plen = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 8));
               rlen = 4'($urandom_range(0, 15));
            end
         endcase
         // small alphabet so partial and overlapping matches show up
         for (int k = 0; k < 8; k++) pat[8*k +: 8] = sym[$urandom_range(0, 2)];
         if (phase < 3 || $urandom_range(0, 3) != 0)
            write_reg(REG_PATTERN_BYTES, pat, 1'b1);
         if (phase < 3 || $urandom_range(0, 3) != 0)
            write_reg(REG_PATTERN_LENGTH, {32'($urandom), 28'($urandom), plen}, 1'b1);
         if (phase < 3 || $urandom_range(0, 3) != 0)
            write_reg(REG_REPLACEMENT_BYTES, {32'($urandom), 32'($urandom)}, 1'b1);
         write_reg(REG_REPLACEMENT_LENGTH, {32'($urandom), 28'($urandom), rlen});
         budget = 13;
         while (budget > 0) begin
            seg.delete();
            pick = $urandom_range(0, 9);
            len = active_pat_len();
            if (pick <= 6) begin
               cut = (pick <= 4) ? len : $urandom_range(0, len - 1);
               for (int k = 0; k < cut; k++) seg = {seg, pat_bytes_cfg[8*k +: 8]};
               if (pick > 4) seg = {seg, sym[$urandom_range(0, 2)]};
            end else if (pick <= 8) begin
               seg = {seg, sym[$urandom_range(0, 2)]};
            end else begin
               seg = {seg, 8'($urandom)};
            end
            foreach (seg[k]) begin
               send_byte(seg[k], $urandom_range(0, 11) == 0);
               budget--;
            end
         end
      end
   endtask

   initial begin
      pat_bytes_cfg = 64'd0;
      pat_len_cfg   = 4'd1;
      rep_bytes_cfg = 64'd0;
      rep_len_cfg   = 4'd0;
      match_total   = 0;
      clear_window();
      req_bus.valid     <= 1'b0;
      req_bus.in_byte   <= 8'h00;
      req_bus.in_last   <= 1'b0;
      csr_bus.valid     <= 1'b0;
      csr_bus.reg_index <= REG_PATTERN_BYTES;
      csr_bus.reg_data  <= 64'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_match_and_flush();
      test_length_limits();
      test_midtext_writes();
      test_match_count();
      test_random_texts();
      settle();
      if (error_count == 0)
         $display("** substring_replace_engine: PASSED **");
      else
         $display("** substring_replace_engine: FAILED **");
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("** substring_replace_engine: FAILED **");
      $finish;
   end

endmodule
